// ----- src/elevator_trip_sequencer_defines.svh -----
// Assertion macros for the trip sequencer
`ifndef ELEVATOR_TRIP_SEQUENCER_DEFINES_SVH
`define ELEVATOR_TRIP_SEQUENCER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define ETS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ETS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ets_pkg.sv -----
package ets_pkg;

  localparam int FLOORS  = 8;
  localparam int FLOOR_W = 3;
  localparam int LANES   = (FLOORS < 8) ? FLOORS : 8;

  localparam logic [FLOOR_W-1:0] TOP_FLOOR = FLOOR_W'(LANES - 1);
  localparam logic [7:0]         LANE_MASK = 8'((1 << LANES) - 1);

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_MOVE  = 3'd1,
    PH_BRAKE = 3'd2,
    PH_STOP  = 3'd3,
    PH_OPEN  = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    SP_AT    = 2'd0,
    SP_LEAVE = 2'd1,
    SP_FAST  = 2'd2,
    SP_ENTER = 2'd3
  } speed_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_MULTI = 2'd1,
    ERR_SKIP  = 2'd2,
    ERR_BRAKE = 2'd3
  } err_t;

  typedef struct packed {
    logic rel;
    logic down;
    logic run;
    logic en;
  } drive_t;

  typedef struct packed {
    logic               req_type;
    logic [FLOOR_W-1:0] start_floor;
    logic [FLOOR_W-1:0] dest_floor;
    logic [7:0]         floor_sensors;
    logic               slow_sensor;
    logic [7:0]         door_sensors;
  } req_t;

  typedef struct packed {
    logic               drive_enable;
    logic               drive_run;
    logic               drive_down;
    logic               brake_release;
    logic [7:0]         door_unlock;
    logic [FLOOR_W-1:0] floor_now;
    logic [1:0]         speed_phase;
    logic [2:0]         trip_phase;
    logic [1:0]         error_code;
    logic               trip_done;
  } res_t;

  typedef struct packed {
    phase_t             phase;
    speed_t             speed;
    logic [FLOOR_W-1:0] cur;
    logic [FLOOR_W-1:0] prev;
    logic [FLOOR_W-1:0] target;
    logic [FLOOR_W-1:0] source;
    logic [7:0]         unlock;
    drive_t             lines;
    err_t               err;
  } state_t;

  localparam state_t ST_RESET = '{
    phase:  PH_IDLE,
    speed:  SP_AT,
    cur:    '0,
    prev:   '0,
    target: '0,
    source: '0,
    unlock: '0,
    lines:  '0,
    err:    ERR_NONE
  };

  function automatic logic [FLOOR_W-1:0] absdiff(input logic [FLOOR_W-1:0] a,
                                                 input logic [FLOOR_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [FLOOR_W-1:0] clamp_floor(input logic [FLOOR_W-1:0] f);
    return (f > TOP_FLOOR) ? TOP_FLOOR : f;
  endfunction

endpackage

// ----- src/ets_if.sv -----
interface ets_req_if import ets_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ets_res_if import ets_pkg::*; ();
  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- src/elevator_trip_sequencer.sv -----
// channel | dir | payload
// req     | in  | req_type, start_floor, dest_floor, floor_sensors, slow_sensor, door_sensors
// res     | out | drive lines, door_unlock, floor_now, speed_phase, trip_phase, error_code,
//         |     | trip_done
// One transaction in gives one out; it passes through the input register, then the result register.
// One transaction per cycle while the result is not stalled: input register, one combinational step, result register.
// rst is synchronous, active high; it clears the trip state and both valid flags.
// A stalled result holds; the input register takes one more transaction, then ready drops.
`include "elevator_trip_sequencer_defines.svh"

module elevator_trip_sequencer import ets_pkg::*; (
  input logic      clk,
  input logic      rst,
  ets_req_if.sink  req,
  ets_res_if.source res
);

  logic   s1_valid;
  req_t   s1_item;
  state_t st;
  state_t st_next;
  res_t   result;
  logic   out_valid;
  res_t   out_data;
  logic   adv;

  assign adv         = s1_valid && (!out_valid || res.ready);
  assign req.ready   = !s1_valid || adv;
  assign res.valid   = out_valid;
  assign res.payload = out_data;

  ets_step u_step (
    .item    (s1_item),
    .st      (st),
    .st_next (st_next),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= ST_RESET;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (adv) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item <= req.payload;
    end
    if (adv) begin
      out_data <= result;
    end
  end

  `ETS_ASSERT_NOW(a_lines_off_at_door, (st.phase == PH_OPEN || st.phase == PH_DONE),
                  (st.lines == '0), "drive lines active while door phase")
  `ETS_ASSERT_NOW(a_no_take_when_full, (s1_valid && out_valid && !res.ready),
                  (!req.ready), "input taken while both stages full")
  `ETS_ASSERT_NEXT(a_start_clears, (adv && s1_item.req_type == REQ_START),
                   (st.unlock == '0 && st.speed == SP_AT), "trip start did not clear state")
  `ETS_ASSERT_NOW(a_floor_range, 1'b1,
                  (st.cur <= TOP_FLOOR && st.prev <= TOP_FLOOR), "floor out of range")

endmodule

// ----- src/ets_step.sv -----
module ets_step import ets_pkg::*; (
  input  req_t   item,
  input  state_t st,
  output state_t st_next,
  output res_t   result
);

  logic               seen;
  logic               multi;
  logic [FLOOR_W-1:0] dprev;
  logic [FLOOR_W-1:0] dtgt;
  logic [FLOOR_W-1:0] src;
  logic [FLOOR_W-1:0] tgt;

  always_comb begin
    st_next = st;
    seen    = 1'b0;
    multi   = 1'b0;
    dprev   = '0;
    dtgt    = '0;
    src     = clamp_floor(item.start_floor);
    tgt     = clamp_floor(item.dest_floor);

    if (item.req_type == REQ_START) begin
      st_next.source = src;
      st_next.target = tgt;
      st_next.cur    = src;
      st_next.prev   = src;
      st_next.speed  = SP_AT;
      st_next.unlock = '0;
      st_next.phase  = (src == tgt) ? PH_STOP : PH_MOVE;
    end else begin
      // floor encode: highest lit lane wins
      for (int i = 0; i < LANES; i++) begin
        if (item.floor_sensors[i]) begin
          if (seen) begin
            multi = 1'b1;
          end
          seen        = 1'b1;
          st_next.cur = FLOOR_W'(i);
        end
      end
      if (multi) begin
        st_next.err = ERR_MULTI;
      end

      dprev = absdiff(st_next.prev, st_next.cur);
      case (dprev)
        3'd0: begin
          if (item.slow_sensor) begin
            if (st_next.speed == SP_AT) begin
              st_next.speed = SP_LEAVE;
            end else if (st_next.speed == SP_FAST) begin
              st_next.speed = SP_ENTER;
            end
          end else begin
            st_next.speed = SP_FAST;
          end
        end
        3'd1: begin
          st_next.prev  = st_next.cur;
          st_next.speed = SP_AT;
        end
        default: begin
          st_next.prev  = st_next.cur;
          st_next.speed = SP_AT;
          st_next.err   = ERR_SKIP;
        end
      endcase

      case (st_next.phase)
        PH_MOVE: begin
          dtgt = absdiff(st_next.cur, st_next.target);
          if (dtgt == '0) begin
            st_next.phase = PH_STOP;
            st_next.err   = ERR_BRAKE;
          end else if (dtgt == FLOOR_W'(1) && st_next.speed == SP_ENTER) begin
            st_next.phase = PH_BRAKE;
          end
          if (st_next.source == st_next.target) begin
            st_next.lines.en  = 1'b1;
            st_next.lines.run = 1'b0;
            st_next.lines.rel = 1'b1;
          end else begin
            st_next.lines.en   = 1'b1;
            st_next.lines.run  = 1'b1;
            st_next.lines.rel  = 1'b1;
            st_next.lines.down = (st_next.source > st_next.target);
          end
        end
        PH_BRAKE: begin
          if (st_next.speed == SP_AT || st_next.cur == st_next.target) begin
            st_next.phase = PH_STOP;
          end
          st_next.lines.en  = 1'b1;
          st_next.lines.run = 1'b0;
          st_next.lines.rel = 1'b1;
        end
        PH_STOP: begin
          st_next.lines = '0;
          st_next.phase = PH_OPEN;
        end
        PH_OPEN: begin
          st_next.unlock[st_next.cur] = 1'b1;
          if ((item.door_sensors & LANE_MASK) != 8'd0) begin
            st_next.phase = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    result.drive_enable  = st_next.lines.en;
    result.drive_run     = st_next.lines.run;
    result.drive_down    = st_next.lines.down;
    result.brake_release = st_next.lines.rel;
    result.door_unlock   = st_next.unlock;
    result.floor_now     = st_next.cur;
    result.speed_phase   = st_next.speed;
    result.trip_phase    = st_next.phase;
    result.error_code    = st_next.err;
    result.trip_done     = (st_next.phase == PH_DONE);
  end

endmodule
